// File: rtl/rotated_particle_mass_projection_macros.svh
// Assertion macros for the particle mass projection block.
`ifndef ROTATED_PARTICLE_MASS_PROJECTION_MACROS_SVH
`define ROTATED_PARTICLE_MASS_PROJECTION_MACROS_SVH
// Same-cycle implication.
`define RPMP_ASSERT_NOW(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("rpmp check failed");
// Next-cycle implication.
`define RPMP_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("rpmp check failed");
`endif

// File: rtl/rpmp_pkg.sv
// Shared types and constants of the particle mass projection block.
package rpmp_pkg;
   localparam int DEF_MAX_COLS = 256;
   localparam int DEF_MAX_ROWS = 256;
   localparam int DEF_SUM_BITS = 48;

   localparam logic [2:0] CSR_ROT_X  = 3'd0;
   localparam logic [2:0] CSR_ROT_Y  = 3'd1;
   localparam logic [2:0] CSR_ROT_Z  = 3'd2;
   localparam logic [2:0] CSR_DEPTH  = 3'd3;
   localparam logic [2:0] CSR_ORIGIN = 3'd4;
   localparam logic [2:0] CSR_SCALE  = 3'd5;
   localparam logic [2:0] CSR_XPIX   = 3'd6;
   localparam logic [2:0] CSR_YPIX   = 3'd7;

   localparam logic [1:0] OP_DROP = 2'd0;
   localparam logic [1:0] OP_ECHO = 2'd1;
   localparam logic [1:0] OP_READ = 2'd2;
   localparam logic [1:0] OP_ADD  = 2'd3;

   typedef struct packed {
      logic [1:0]  op;
      logic [7:0]  col;
      logic [7:0]  row;
      logic [31:0] mass;
   } item_type;
endpackage

// File: rtl/rotated_particle_mass_projection.sv
// From accept to result a particle passes the front states MUL, SUM, DIF, BIN and CLS, the
// queue and, when it lands in the image, a store read and write-back in B_RD; a read goes
// from IDLE straight to CLS and the queue, and skips B_RD when it falls outside the store.
// The front takes no new request until back in IDLE; the back pops only when idle and no result waits.
// Reset (synchronous): registers return to defaults and all MAX_COLS*MAX_ROWS entries
// (65536 by default) of the pixel store are zeroed, with req_full high.
module rotated_particle_mass_projection #(
   parameter int MAX_COLS = rpmp_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = rpmp_pkg::DEF_MAX_ROWS,
   parameter int SUM_BITS = rpmp_pkg::DEF_SUM_BITS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_cmd,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [31:0]        req_particle_mass,
   input  logic [7:0]         req_read_col,
   input  logic [7:0]         req_read_row,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_binned,
   output logic [7:0]         rsp_pixel_col,
   output logic [7:0]         rsp_pixel_row,
   output logic [47:0]        rsp_pixel_sum,
   output logic               rsp_saturated
);
   import rpmp_pkg::*;
`include "rotated_particle_mass_projection_macros.svh"

   logic     clearing, q_push, q_full, q_pop, q_empty;
   item_type q_wdata, q_rdata;

   rpmp_front #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS)) u_front (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_push          (req_push),
      .req_full          (req_full),
      .req_cmd           (req_cmd),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_particle_mass (req_particle_mass),
      .req_read_col      (req_read_col),
      .req_read_row      (req_read_row),
      .hold              (clearing),
      .q_push            (q_push),
      .q_data            (q_wdata),
      .q_full            (q_full)
   );

   rpmp_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (q_push),
      .wdata (q_wdata),
      .full  (q_full),
      .pop   (q_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   rpmp_back #(.MAX_COLS(MAX_COLS), .MAX_ROWS(MAX_ROWS), .SUM_BITS(SUM_BITS)) u_back (
      .clock         (clock),
      .reset         (reset),
      .clearing      (clearing),
      .q_pop         (q_pop),
      .q_data        (q_rdata),
      .q_empty       (q_empty),
      .rsp_empty     (rsp_empty),
      .rsp_pop       (rsp_pop),
      .rsp_binned    (rsp_binned),
      .rsp_pixel_col (rsp_pixel_col),
      .rsp_pixel_row (rsp_pixel_row),
      .rsp_pixel_sum (rsp_pixel_sum),
      .rsp_saturated (rsp_saturated)
   );

   `RPMP_ASSERT_NOW(a_full_while_clearing, clearing, req_full)
   `RPMP_ASSERT_NEXT(a_busy_after_accept, req_push && !req_full, req_full)
   `RPMP_ASSERT_NOW(a_sat_only_binned, !rsp_empty && rsp_saturated, rsp_binned)
   `RPMP_ASSERT_NOW(a_no_pop_while_clearing, clearing, !q_pop && q_empty)
endmodule

// File: rtl/rpmp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
module rpmp_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 65536,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic             re,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

// File: rtl/rpmp_queue.sv
// Two-entry queue between the classifier and the accumulator.
module rpmp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  rpmp_pkg::item_type wdata,
   output logic              full,
   input  logic              pop,
   output rpmp_pkg::item_type rdata,
   output logic              empty
);
   import rpmp_pkg::*;

   item_type   slot_ff [2];
   logic       wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = slot_ff[rptr_ff];

   always_comb begin
      wptr_in  = do_push ? !wptr_ff : wptr_ff;
      rptr_in  = do_pop ? !rptr_ff : rptr_ff;
      count_in = count_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (do_push) begin
         slot_ff[wptr_ff] <= wdata;
      end
   end
endmodule

// File: rtl/rpmp_front.sv
// Front end: registers, rotation, depth test and pixel binning.
module rpmp_front #(
   parameter int MAX_COLS = rpmp_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = rpmp_pkg::DEF_MAX_ROWS
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_wdata,
   input  logic               req_push,
   output logic               req_full,
   input  logic               req_cmd,
   input  logic signed [31:0] req_pos_x,
   input  logic signed [31:0] req_pos_y,
   input  logic signed [31:0] req_pos_z,
   input  logic [31:0]        req_particle_mass,
   input  logic [7:0]         req_read_col,
   input  logic [7:0]         req_read_row,
   input  logic               hold,
   output logic               q_push,
   output rpmp_pkg::item_type q_data,
   input  logic               q_full
);
   import rpmp_pkg::*;

   localparam logic [8:0]  CAP_COLS = 9'((MAX_COLS < 256) ? MAX_COLS : 256);
   localparam logic [8:0]  CAP_ROWS = 9'((MAX_ROWS < 256) ? MAX_ROWS : 256);
   localparam logic [12:0] STORE_COLS = 13'(MAX_COLS);
   localparam logic [12:0] STORE_ROWS = 13'(MAX_ROWS);

   typedef enum logic [5:0] {
      F_IDLE = 6'b000001,
      F_MUL  = 6'b000010,
      F_SUM  = 6'b000100,
      F_DIF  = 6'b001000,
      F_BIN  = 6'b010000,
      F_CLS  = 6'b100000
   } fstate_type;

   fstate_type state_ff, state_in;

   logic [53:0] rot_ff [3];
   logic [63:0] depth_ff, origin_ff, scale_ff;
   logic [8:0]  xpix_ff, ypix_ff;

   logic               cmd_ff;
   logic signed [31:0] pos_ff [3];
   logic [31:0]        mass_ff;
   logic [7:0]         rcol_ff, rrow_ff;
   logic signed [49:0] prod_ff [3][3];
   logic signed [51:0] rsum_ff [3];
   logic               depth_ok_ff;
   logic               neg_ff [2];
   logic [52:0]        mag_ff [2];
   logic [63:0]        plo_ff [2];
   logic [52:0]        phi_ff [2];

   logic               accept;
   logic signed [52:0] dif [2];
   logic signed [52:0] zmin, zmax, rz;
   logic [37:0]        q [2];
   logic [8:0]         lim [2];
   logic               hit [2];

   assign accept   = req_push && !req_full;
   assign req_full = (state_ff != F_IDLE) || hold;

   always_comb begin
      lim[0] = (xpix_ff > CAP_COLS) ? CAP_COLS : xpix_ff;
      lim[1] = (ypix_ff > CAP_ROWS) ? CAP_ROWS : ypix_ff;
      zmin   = 53'($signed(depth_ff[31:0])) <<< 16;
      zmax   = 53'($signed(depth_ff[63:32])) <<< 16;
      rz     = 53'(rsum_ff[2]);
      for (int k = 0; k < 2; k++) begin
         dif[k] = 53'(rsum_ff[k]) - (53'($signed(origin_ff[32*k +: 32])) <<< 16);
         q[k]   = 38'((54'(phi_ff[k]) + 54'(plo_ff[k][63:32])) >> 16);
         hit[k] = neg_ff[k] ? (q[k] == 38'd0 && lim[k] != 9'd0) : (q[k] < 38'(lim[k]));
      end
   end

   always_comb begin
      q_data.col  = rcol_ff;
      q_data.row  = rrow_ff;
      q_data.mass = mass_ff;
      if (cmd_ff) begin
         q_data.op = (13'(rcol_ff) < STORE_COLS && 13'(rrow_ff) < STORE_ROWS) ?
                     OP_READ : OP_ECHO;
      end else begin
         q_data.col = q[0][7:0];
         q_data.row = q[1][7:0];
         q_data.op  = (depth_ok_ff && hit[0] && hit[1]) ? OP_ADD : OP_DROP;
      end
   end

   assign q_push = (state_ff == F_CLS);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: if (accept) state_in = req_cmd ? F_CLS : F_MUL;
         F_MUL:  state_in = F_SUM;
         F_SUM:  state_in = F_DIF;
         F_DIF:  state_in = F_BIN;
         F_BIN:  state_in = F_CLS;
         F_CLS:  if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= F_IDLE;
         rot_ff[0] <= 54'd65536;
         rot_ff[1] <= 54'd65536 << 18;
         rot_ff[2] <= 54'd65536 << 36;
         depth_ff  <= '0;
         origin_ff <= '0;
         scale_ff  <= '0;
         xpix_ff   <= 9'd256;
         ypix_ff   <= 9'd256;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            case (csr_index)
               CSR_ROT_X:  rot_ff[0] <= csr_wdata[53:0];
               CSR_ROT_Y:  rot_ff[1] <= csr_wdata[53:0];
               CSR_ROT_Z:  rot_ff[2] <= csr_wdata[53:0];
               CSR_DEPTH:  depth_ff  <= csr_wdata;
               CSR_ORIGIN: origin_ff <= csr_wdata;
               CSR_SCALE:  scale_ff  <= csr_wdata;
               CSR_XPIX:   xpix_ff   <= csr_wdata[8:0];
               CSR_YPIX:   ypix_ff   <= csr_wdata[8:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cmd_ff    <= req_cmd;
         pos_ff[0] <= req_pos_x;
         pos_ff[1] <= req_pos_y;
         pos_ff[2] <= req_pos_z;
         mass_ff   <= req_particle_mass;
         rcol_ff   <= req_read_col;
         rrow_ff   <= req_read_row;
      end
      if (state_ff == F_MUL) begin
         for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
               prod_ff[r][c] <= $signed(rot_ff[r][18*c +: 18]) * pos_ff[c];
            end
         end
      end
      if (state_ff == F_SUM) begin
         for (int r = 0; r < 3; r++) begin
            rsum_ff[r] <= 52'(prod_ff[r][0]) + 52'(prod_ff[r][1]) + 52'(prod_ff[r][2]);
         end
      end
      if (state_ff == F_DIF) begin
         depth_ok_ff <= !(rz < zmin || rz > zmax);
         for (int k = 0; k < 2; k++) begin
            neg_ff[k] <= dif[k][52];
            mag_ff[k] <= dif[k][52] ? 53'(-dif[k]) : 53'(dif[k]);
         end
      end
      if (state_ff == F_BIN) begin
         for (int k = 0; k < 2; k++) begin
            plo_ff[k] <= mag_ff[k][31:0] * scale_ff[32*k +: 32];
            phi_ff[k] <= mag_ff[k][52:32] * scale_ff[32*k +: 32];
         end
      end
   end
endmodule

// File: rtl/rpmp_back.sv
// Back end: store clearing, pixel accumulate and read-and-clear, result word.
module rpmp_back #(
   parameter int MAX_COLS = rpmp_pkg::DEF_MAX_COLS,
   parameter int MAX_ROWS = rpmp_pkg::DEF_MAX_ROWS,
   parameter int SUM_BITS = rpmp_pkg::DEF_SUM_BITS
) (
   input  logic               clock,
   input  logic               reset,
   output logic               clearing,
   output logic               q_pop,
   input  rpmp_pkg::item_type q_data,
   input  logic               q_empty,
   output logic               rsp_empty,
   input  logic               rsp_pop,
   output logic               rsp_binned,
   output logic [7:0]         rsp_pixel_col,
   output logic [7:0]         rsp_pixel_row,
   output logic [47:0]        rsp_pixel_sum,
   output logic               rsp_saturated
);
   import rpmp_pkg::*;

   localparam int DEPTH = MAX_COLS * MAX_ROWS;
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [SUM_BITS-1:0] SUM_MAX = '1;

   typedef enum logic [2:0] {
      B_CLEAR = 3'b001,
      B_IDLE  = 3'b010,
      B_RD    = 3'b100
   } bstate_type;

   bstate_type state_ff, state_in;
   logic [AW-1:0] clr_ff, clr_in;
   item_type      cur_ff;
   logic [AW-1:0] addr_ff, q_addr;

   logic                out_valid_ff;
   logic                out_binned_ff, out_sat_ff;
   logic [7:0]          out_col_ff, out_row_ff;
   logic [47:0]         out_sum_ff;

   logic                ram_we, ram_re;
   logic [AW-1:0]       ram_waddr;
   logic [SUM_BITS-1:0] ram_wdata, old, nw;
   logic                sat;

   assign clearing = (state_ff == B_CLEAR);
   assign q_pop    = (state_ff == B_IDLE) && !q_empty && !out_valid_ff;
   assign q_addr   = AW'(AW'(q_data.row) * AW'(MAX_COLS) + AW'(q_data.col));
   assign ram_re   = q_pop && (q_data.op == OP_READ || q_data.op == OP_ADD);

   always_comb begin
      sat = (SUM_MAX - old) < SUM_BITS'(cur_ff.mass);
      nw  = sat ? SUM_MAX : old + SUM_BITS'(cur_ff.mass);
   end

   always_comb begin
      ram_we    = 1'b0;
      ram_waddr = addr_ff;
      ram_wdata = '0;
      if (state_ff == B_CLEAR) begin
         ram_we    = 1'b1;
         ram_waddr = clr_ff;
      end else if (state_ff == B_RD) begin
         ram_we = 1'b1;
         if (cur_ff.op == OP_ADD) ram_wdata = nw;
      end
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      case (state_ff)
         B_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) state_in = B_IDLE;
         end
         B_IDLE: if (ram_re) state_in = B_RD;
         B_RD:   state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   rpmp_ram #(.WIDTH(SUM_BITS), .DEPTH(DEPTH)) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (q_addr),
      .rdata (old)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         if (q_pop && !ram_re) begin
            out_valid_ff <= 1'b1;
         end else if (state_ff == B_RD) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         cur_ff  <= q_data;
         addr_ff <= q_addr;
      end
      // drop and out-of-store read finish at once
      if (q_pop && !ram_re) begin
         out_binned_ff <= 1'b0;
         out_sat_ff    <= 1'b0;
         out_sum_ff    <= '0;
         out_col_ff    <= (q_data.op == OP_ECHO) ? q_data.col : 8'd0;
         out_row_ff    <= (q_data.op == OP_ECHO) ? q_data.row : 8'd0;
      end else if (state_ff == B_RD) begin
         out_col_ff <= cur_ff.col;
         out_row_ff <= cur_ff.row;
         if (cur_ff.op == OP_ADD) begin
            out_binned_ff <= 1'b1;
            out_sat_ff    <= sat;
            out_sum_ff    <= 48'(64'(nw));
         end else begin
            out_binned_ff <= 1'b0;
            out_sat_ff    <= 1'b0;
            out_sum_ff    <= 48'(64'(old));
         end
      end
   end

   assign rsp_empty     = !out_valid_ff;
   assign rsp_binned    = out_binned_ff;
   assign rsp_pixel_col = out_col_ff;
   assign rsp_pixel_row = out_row_ff;
   assign rsp_pixel_sum = out_sum_ff;
   assign rsp_saturated = out_sat_ff;
endmodule
